// ===== rtl/adbh_pkg.sv =====
// Shared types and constants for the adaptive decade bandwidth histogram.
// Used by adaptive_decade_bandwidth_histogram_unit; depends on nothing else.
package adbh_pkg;

  localparam int COUNT_WIDTH_DEF        = 32;
  localparam int PACKET_BYTES_WIDTH_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int RATE_W   = 40;
  localparam int SIZE_W   = 37;
  localparam int IDX_W    = 4;
  localparam int PCT_W    = 7;
  localparam int TOTAL_W  = 48;
  localparam int SEC_W    = 37;
  localparam int SHIFT_W  = 3;
  localparam int FIXED_W  = 3 * RATE_W + SIZE_W + IDX_W + PCT_W + TOTAL_W;

  localparam int NUM_BUCKETS = 10;

  localparam logic [IDX_W-1:0]   LAST_BUCKET = IDX_W'(NUM_BUCKETS - 1);
  localparam logic [RATE_W-1:0]  RATE_MAX    = 40'd999999999999;
  localparam logic [RATE_W-1:0]  MIN_RESET   = 40'd10000000000;
  localparam logic [SEC_W-1:0]   SEC_CAP     = 37'd124999999999;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 37'd10;
  localparam logic [RATE_W-1:0]  THR_START   = 40'd100;
  localparam logic [SHIFT_W-1:0] SHIFT_TOP   = SHIFT_W'(PCT_W - 1);

  localparam logic [ACTION_W-1:0] ACT_PACKET = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DROP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd3;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_WIDTH,
    ST_FOLD,
    ST_INDEX,
    ST_COUNT,
    ST_TICK_OUT,
    ST_SUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ROW_OUT
  } state_t;

endpackage

// ===== rtl/adaptive_decade_bandwidth_histogram_unit.sv =====
// Traffic statistics with an adaptive decade histogram of per-second bandwidth.
// Depends on adbh_pkg for types, codes and constants.
//
// Packet and drop items are taken in the idle state. A tick steps through the
// rate step, the decade search, a bucket fold when the bucket size grows, the
// bucket search, the count update and the emit step. A report is accepted, sums
// the buckets and then steps through each row (load, 7 restoring division steps,
// emit); with every count zero a row goes from load straight to emit. A full
// output register holds the sequence at its emit step. The decade search, the
// bucket search and the division share one compare-subtract unit, and the steps
// read the bucket array through one port, the fold also reading bucket 0;
// in_tready is low until the sequence ends. Results wait in an output
// register, so the next item is taken while the last result is still pending.
module adaptive_decade_bandwidth_histogram_unit #(
  parameter int COUNT_WIDTH        = adbh_pkg::COUNT_WIDTH_DEF,
  parameter int PACKET_BYTES_WIDTH = adbh_pkg::PACKET_BYTES_WIDTH_DEF,
  localparam int InDataW  = ((PACKET_BYTES_WIDTH + 7) / 8) * 8,
  localparam int OutDataW = ((adbh_pkg::FIXED_W + 3 * COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // packet_bytes
  input  logic [InDataW-1:0]              in_tdata,
  // action
  input  logic [adbh_pkg::ACTION_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // rate_bits, min_bits, max_bits, decade_size, bucket_index, bucket_percent,
  // bucket_count, packet_count, drop_count, total_bytes
  output logic [OutDataW-1:0]             out_tdata,
  // kind
  output logic                            out_tuser,
  output logic                            out_tlast
);

  import adbh_pkg::*;

  localparam int SumW    = COUNT_WIDTH + 4;
  localparam int RemW    = COUNT_WIDTH + 11;
  localparam int CmpW    = (RemW > RATE_W + 4) ? RemW : RATE_W + 4;
  localparam int PayW    = FIXED_W + 3 * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [SEC_W-1:0]       SecMax   = '1;
  localparam logic [TOTAL_W-1:0]     TotalMax = '1;

  state_t                 state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] bucket_r [NUM_BUCKETS];
  logic [COUNT_WIDTH-1:0] bucket_nxt [NUM_BUCKETS];
  logic [SEC_W-1:0]       sec_r, sec_nxt;
  logic [SIZE_W-1:0]      bw_r, bw_nxt;
  logic [SIZE_W-1:0]      need_r, need_nxt;
  logic [RATE_W-1:0]      min_r, min_nxt;
  logic [RATE_W-1:0]      max_r, max_nxt;
  logic [RATE_W-1:0]      bits_r, bits_nxt;
  logic [RATE_W-1:0]      thr_r, thr_nxt;
  logic [COUNT_WIDTH-1:0] pkt_r, pkt_nxt;
  logic [COUNT_WIDTH-1:0] drop_r, drop_nxt;
  logic [TOTAL_W-1:0]     tbytes_r, tbytes_nxt;
  logic [CmpW-1:0]        rem_r, rem_nxt;
  logic [SumW-1:0]        sum_r, sum_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic [PCT_W-1:0]       quot_r, quot_nxt;
  logic [IDX_W-1:0]       ptr_r, ptr_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [OutDataW-1:0]    odata_r, odata_nxt;
  logic                   okind_r, okind_nxt;
  logic                   olast_r, olast_nxt;

  logic [CmpW-1:0]        cmp_a, cmp_b, cmp_diff;
  logic                   cmp_ge;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [COUNT_WIDTH:0]   cnt_inc, cnt_fold;
  logic                   slot_free;
  logic [PACKET_BYTES_WIDTH-1:0] pkt_bytes;
  logic [SEC_W:0]         sec_sum;
  logic [TOTAL_W:0]       tbytes_sum;
  logic [RATE_W-1:0]      rate_calc;
  logic [CmpW-1:0]        cnt_ext;
  logic [PayW-1:0]        pay_tick, pay_row;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  assign slot_free  = !ovalid_r || out_tready;
  assign rd_cnt     = bucket_r[ptr_r];
  assign cnt_inc    = {1'b0, rd_cnt} + (COUNT_WIDTH + 1)'(1);
  assign cnt_fold   = {1'b0, bucket_r[0]} + {1'b0, rd_cnt};
  assign pkt_bytes  = in_tdata[PACKET_BYTES_WIDTH-1:0];
  assign sec_sum    = {1'b0, sec_r} + (SEC_W + 1)'(pkt_bytes);
  assign tbytes_sum = {1'b0, tbytes_r} + (TOTAL_W + 1)'(pkt_bytes);
  assign rate_calc  = (sec_r > SEC_CAP) ? RATE_MAX : {sec_r, 3'b000};
  assign cnt_ext    = CmpW'(rd_cnt);

  assign cmp_ge   = (cmp_a >= cmp_b);
  assign cmp_diff = cmp_a - cmp_b;

  always_comb begin
    case (state_r)
      ST_WIDTH: begin
        cmp_a = CmpW'(bits_r);
        cmp_b = CmpW'(thr_r);
      end
      ST_INDEX: begin
        cmp_a = rem_r;
        cmp_b = CmpW'(bw_r);
      end
      ST_DIV: begin
        cmp_a = rem_r;
        cmp_b = CmpW'(sum_r) << shift_r;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign pay_tick = {tbytes_r, drop_r, pkt_r, rd_cnt, PCT_W'(0), ptr_r, bw_r,
                     max_r, min_r, bits_r};
  assign pay_row  = {tbytes_r, drop_r, pkt_r, rd_cnt, quot_r, ptr_r, bw_r,
                     max_r, min_r, RATE_W'(0)};

  always_comb begin
    state_nxt  = state_r;
    bucket_nxt = bucket_r;
    sec_nxt    = sec_r;
    bw_nxt     = bw_r;
    need_nxt   = need_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    bits_nxt   = bits_r;
    thr_nxt    = thr_r;
    pkt_nxt    = pkt_r;
    drop_nxt   = drop_r;
    tbytes_nxt = tbytes_r;
    rem_nxt    = rem_r;
    sum_nxt    = sum_r;
    shift_nxt  = shift_r;
    quot_nxt   = quot_r;
    ptr_nxt    = ptr_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ACT_PACKET: begin
              pkt_nxt    = (pkt_r == CountMax) ? CountMax : pkt_r + COUNT_WIDTH'(1);
              sec_nxt    = sec_sum[SEC_W] ? SecMax : sec_sum[SEC_W-1:0];
              tbytes_nxt = tbytes_sum[TOTAL_W] ? TotalMax : tbytes_sum[TOTAL_W-1:0];
            end
            ACT_DROP: begin
              drop_nxt = (drop_r == CountMax) ? CountMax : drop_r + COUNT_WIDTH'(1);
            end
            ACT_TICK: begin
              state_nxt = ST_RATE;
            end
            ACT_REPORT: begin
              sum_nxt   = '0;
              ptr_nxt   = '0;
              state_nxt = ST_SUM;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RATE: begin
        bits_nxt = rate_calc;
        if (rate_calc > max_r) max_nxt = rate_calc;
        if (rate_calc < min_r) min_nxt = rate_calc;
        need_nxt  = SIZE_RESET;
        thr_nxt   = THR_START;
        state_nxt = ST_WIDTH;
      end
      ST_WIDTH: begin
        if (cmp_ge) begin
          need_nxt = (need_r << 3) + (need_r << 1);
          thr_nxt  = (thr_r << 3) + (thr_r << 1);
        end else if (need_r > bw_r) begin
          bw_nxt    = need_r;
          ptr_nxt   = IDX_W'(1);
          state_nxt = ST_FOLD;
        end else begin
          rem_nxt   = CmpW'(bits_r);
          ptr_nxt   = '0;
          state_nxt = ST_INDEX;
        end
      end
      ST_FOLD: begin
        bucket_nxt[0]     = cnt_fold[COUNT_WIDTH] ? CountMax : cnt_fold[COUNT_WIDTH-1:0];
        bucket_nxt[ptr_r] = '0;
        if (ptr_r == LAST_BUCKET) begin
          rem_nxt   = CmpW'(bits_r);
          ptr_nxt   = '0;
          state_nxt = ST_INDEX;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      ST_INDEX: begin
        if (ptr_r == LAST_BUCKET || !cmp_ge) begin
          state_nxt = ST_COUNT;
        end else begin
          rem_nxt = cmp_diff;
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      ST_COUNT: begin
        bucket_nxt[ptr_r] = cnt_inc[COUNT_WIDTH] ? CountMax : cnt_inc[COUNT_WIDTH-1:0];
        sec_nxt           = '0;
        state_nxt         = ST_TICK_OUT;
      end
      ST_TICK_OUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = '0;
          odata_nxt[PayW-1:0] = pay_tick;
          okind_nxt  = KIND_TICK;
          olast_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_r + SumW'(rd_cnt);
        if (ptr_r == LAST_BUCKET) begin
          ptr_nxt   = '0;
          state_nxt = ST_DIV_LOAD;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      ST_DIV_LOAD: begin
        rem_nxt   = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
        shift_nxt = SHIFT_TOP;
        quot_nxt  = '0;
        state_nxt = (sum_r == '0) ? ST_ROW_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (cmp_ge) begin
          rem_nxt           = cmp_diff;
          quot_nxt[shift_r] = 1'b1;
        end
        if (shift_r == '0) begin
          state_nxt = ST_ROW_OUT;
        end else begin
          shift_nxt = shift_r - SHIFT_W'(1);
        end
      end
      ST_ROW_OUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = '0;
          odata_nxt[PayW-1:0] = pay_row;
          okind_nxt  = KIND_ROW;
          olast_nxt  = (ptr_r == LAST_BUCKET);
          if (ptr_r == LAST_BUCKET) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r + IDX_W'(1);
            state_nxt = ST_DIV_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      for (int i = 0; i < NUM_BUCKETS; i++) bucket_r[i] <= '0;
      sec_r    <= '0;
      bw_r     <= SIZE_RESET;
      min_r    <= MIN_RESET;
      max_r    <= '0;
      pkt_r    <= '0;
      drop_r   <= '0;
      tbytes_r <= '0;
      ptr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bucket_r <= bucket_nxt;
      sec_r    <= sec_nxt;
      bw_r     <= bw_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      pkt_r    <= pkt_nxt;
      drop_r   <= drop_nxt;
      tbytes_r <= tbytes_nxt;
      ptr_r    <= ptr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r  <= need_nxt;
    bits_r  <= bits_nxt;
    thr_r   <= thr_nxt;
    rem_r   <= rem_nxt;
    sum_r   <= sum_nxt;
    shift_r <= shift_nxt;
    quot_r  <= quot_nxt;
    odata_r <= odata_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// ===== sim/adaptive_decade_bandwidth_histogram_unit_tb.sv =====
// Self-checking bench for adaptive_decade_bandwidth_histogram_unit: directed and random
// packet, drop, tick and report items with random stalls on both streams.
// Depends on adbh_pkg and the unit itself; predicts every result row in a scoreboard class.
`timescale 1ns / 1ps

module adaptive_decade_bandwidth_histogram_unit_tb;
  import adbh_pkg::*;

  localparam int COUNT_W = COUNT_WIDTH_DEF;
  localparam int BYTES_W = PACKET_BYTES_WIDTH_DEF;
  localparam int IN_W    = ((BYTES_W + 7) / 8) * 8;
  localparam int OUT_W   = ((FIXED_W + 3 * COUNT_W + 7) / 8) * 8;

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;
  localparam longint unsigned SEC_MAX   = (64'd1 << SEC_W) - 1;
  localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 1;
  localparam longint unsigned BYTES_MAX = (64'd1 << BYTES_W) - 1;

  typedef struct packed {
    bit [TOTAL_W-1:0] total_bytes;
    bit [COUNT_W-1:0] drop_count;
    bit [COUNT_W-1:0] packet_count;
    bit [COUNT_W-1:0] bucket_count;
    bit [PCT_W-1:0]   bucket_percent;
    bit [IDX_W-1:0]   bucket_index;
    bit [SIZE_W-1:0]  decade_size;
    bit [RATE_W-1:0]  max_bits;
    bit [RATE_W-1:0]  min_bits;
    bit [RATE_W-1:0]  rate_bits;
  } stats_word_t;

  typedef struct {
    bit          kind;
    stats_word_t w;
    bit          last;
  } stats_row_t;

  class histogram_tracker;
    longint unsigned sec_bytes;
    longint unsigned width;
    longint unsigned counts[NUM_BUCKETS];
    longint unsigned low_rate;
    longint unsigned high_rate;
    longint unsigned pkts;
    longint unsigned drops;
    longint unsigned bytes_total;
    longint unsigned widest;
    stats_row_t      pending_rows[$];
    int              errors;
    int              rows_checked;
    int              n_packets, n_drops, n_ticks, n_reports, n_folds;

    function new();
      sec_bytes   = 0;
      width       = SIZE_RESET;
      foreach (counts[i]) counts[i] = 0;
      low_rate    = MIN_RESET;
      high_rate   = 0;
      pkts        = 0;
      drops       = 0;
      bytes_total = 0;
      widest      = SIZE_RESET;
      errors      = 0;
      rows_checked = 0;
      n_packets = 0; n_drops = 0; n_ticks = 0; n_reports = 0; n_folds = 0;
    endfunction

    function longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                      longint unsigned cap);
      if (a > cap) a = cap;
      if (b > cap - a) return cap;
      return a + b;
    endfunction

    function longint unsigned decade_for(longint unsigned bits);
      longint unsigned size;
      longint unsigned n;
      size = 10;
      n = bits / 100;
      while (n != 0) begin
        n = n / 10;
        size = size * 10;
      end
      return size;
    endfunction

    function stats_row_t make_row(bit kind, longint unsigned rate, longint unsigned idx,
                                  longint unsigned pct, longint unsigned cnt, bit last);
      stats_row_t r;
      r.kind             = kind;
      r.last             = last;
      r.w.rate_bits      = rate[RATE_W-1:0];
      r.w.min_bits       = low_rate[RATE_W-1:0];
      r.w.max_bits       = high_rate[RATE_W-1:0];
      r.w.decade_size    = width[SIZE_W-1:0];
      r.w.bucket_index   = idx[IDX_W-1:0];
      r.w.bucket_percent = pct[PCT_W-1:0];
      r.w.bucket_count   = cnt[COUNT_W-1:0];
      r.w.packet_count   = pkts[COUNT_W-1:0];
      r.w.drop_count     = drops[COUNT_W-1:0];
      r.w.total_bytes    = bytes_total[TOTAL_W-1:0];
      return r;
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, logic [IN_W-1:0] data);
      longint unsigned b, bits, need, idx, total, pct;
      b = longint'(data) & BYTES_MAX;
      case (act)
        ACT_PACKET: begin
          n_packets++;
          pkts        = sat_sum(pkts, 1, COUNT_MAX);
          sec_bytes   = sat_sum(sec_bytes, b, SEC_MAX);
          bytes_total = sat_sum(bytes_total, b, TOTAL_MAX);
        end
        ACT_DROP: begin
          n_drops++;
          drops = sat_sum(drops, 1, COUNT_MAX);
        end
        ACT_TICK: begin
          n_ticks++;
          bits = (sec_bytes > RATE_MAX / 8) ? RATE_MAX : sec_bytes * 8;
          if (bits > RATE_MAX) bits = RATE_MAX;
          if (bits > high_rate) high_rate = bits;
          if (bits < low_rate) low_rate = bits;
          need = decade_for(bits);
          if (need > width) begin
            n_folds++;
            width = need;
            if (width > widest) widest = width;
            for (int i = 1; i < NUM_BUCKETS; i++) begin
              counts[0] = sat_sum(counts[0], counts[i], COUNT_MAX);
              counts[i] = 0;
            end
          end
          idx = bits / width;
          if (idx > NUM_BUCKETS - 1) idx = NUM_BUCKETS - 1;
          counts[idx] = sat_sum(counts[idx], 1, COUNT_MAX);
          sec_bytes = 0;
          pending_rows.push_back(make_row(KIND_TICK, bits, idx, 0, counts[idx], 1'b1));
        end
        default: begin
          n_reports++;
          total = 0;
          foreach (counts[i]) total += counts[i];
          for (int i = 0; i < NUM_BUCKETS; i++) begin
            pct = (total == 0) ? 0 : (counts[i] * 100) / total;
            if (pct > 100) pct = 100;
            pending_rows.push_back(make_row(KIND_ROW, 0, i, pct, counts[i],
                                            i == NUM_BUCKETS - 1));
          end
        end
      endcase
    endfunction

    function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_row(bit kind, bit [OUT_W-1:0] data, bit last);
      stats_row_t  e;
      stats_word_t a;
      if (pending_rows.size() == 0) begin
        $error("result with nothing pending: kind %0d data %h", kind, data);
        errors++;
        return;
      end
      e = pending_rows.pop_front();
      a = stats_word_t'(data);
      rows_checked++;
      compare("kind", e.kind, kind);
      compare("rate_bits", e.w.rate_bits, a.rate_bits);
      compare("min_bits", e.w.min_bits, a.min_bits);
      compare("max_bits", e.w.max_bits, a.max_bits);
      compare("decade_size", e.w.decade_size, a.decade_size);
      compare("bucket_index", e.w.bucket_index, a.bucket_index);
      compare("bucket_percent", e.w.bucket_percent, a.bucket_percent);
      compare("bucket_count", e.w.bucket_count, a.bucket_count);
      compare("packet_count", e.w.packet_count, a.packet_count);
      compare("drop_count", e.w.drop_count, a.drop_count);
      compare("total_bytes", e.w.total_bytes, a.total_bytes);
      compare("last", e.last, last);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic [ACTION_W-1:0] in_tuser = ACT_PACKET;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  bit hold_req = 1'b0;
  bit steady   = 1'b0;

  histogram_tracker sb;

  adaptive_decade_bandwidth_histogram_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [IN_W-1:0] nbytes);
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= nbytes;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(act, nbytes);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_bytes();
    int r;
    r = $urandom_range(99);
    if (r < 40) return IN_W'($urandom_range(31));
    if (r < 80) return IN_W'($urandom);
    if (r < 90) return IN_W'(BYTES_MAX);
    return '0;
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        repeat (400) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      out_tready <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tuser, out_tdata, out_tlast);
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int r;
    int burst;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty histogram, zero-rate second, growth from 10 to 100 and to 10^6
    send_item(ACT_REPORT, '0);
    send_item(ACT_TICK, '1);
    send_item(ACT_PACKET, '0);
    send_item(ACT_PACKET, IN_W'(1));
    send_item(ACT_DROP, '1);
    send_item(ACT_TICK, '0);
    send_item(ACT_PACKET, IN_W'(12));
    send_item(ACT_TICK, '0);
    send_item(ACT_PACKET, IN_W'(13));
    send_item(ACT_TICK, '0);
    send_item(ACT_REPORT, '1);
    send_item(ACT_PACKET, IN_W'(BYTES_MAX));
    send_item(ACT_PACKET, IN_W'(BYTES_MAX));
    send_item(ACT_TICK, '0);
    send_item(ACT_PACKET, IN_W'(16'h5555));
    send_item(ACT_PACKET, IN_W'(16'hAAAA));
    send_item(ACT_DROP, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_REPORT, '0);
    send_item(ACT_TICK, '0);
    send_item(ACT_REPORT, '0);

    for (int n = 0; n < 190; n++) begin
      if (n == 120) begin
        hold_req = 1'b1;
        repeat (6) send_item(ACT_TICK, pick_bytes());
        send_item(ACT_REPORT, pick_bytes());
        send_item(ACT_TICK, pick_bytes());
        send_item(ACT_REPORT, pick_bytes());
        drain();
      end
      if (n == 150) steady = 1'b1;
      if (n == 180) steady = 1'b0;
      r = $urandom_range(99);
      if (r < 4) begin
        burst = $urandom_range(8, 3);
        repeat (burst) send_item(ACT_PACKET, IN_W'($urandom_range(32'(BYTES_MAX), 40000)));
        send_item(ACT_TICK, pick_bytes());
      end else if (r < 62) begin
        send_item(ACT_PACKET, pick_bytes());
      end else if (r < 74) begin
        send_item(ACT_DROP, pick_bytes());
      end else if (r < 90) begin
        send_item(ACT_TICK, pick_bytes());
      end else begin
        send_item(ACT_REPORT, pick_bytes());
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (sb.pending_rows.size() != 0) begin
      $error("%0d results never arrived", sb.pending_rows.size());
      sb.errors++;
    end
    $display("Covered %0d packets, %0d drops, %0d ticks, %0d reports, %0d bucket folds.",
             sb.n_packets, sb.n_drops, sb.n_ticks, sb.n_reports, sb.n_folds);
    $display("Checked %0d result rows; widest bucket size %0d bits/s.",
             sb.rows_checked, sb.widest);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/adbh_pkg.sv
rtl/adaptive_decade_bandwidth_histogram_unit.sv
sim/adaptive_decade_bandwidth_histogram_unit_tb.sv
